// File: hw/rtl/ctls_pkg.sv
// ----------------------------------------------------------------------------
// ctls_pkg
// Shared types and codes for the token scanner: scan modes, token kinds,
// error codes and the result and result-group records.
// ----------------------------------------------------------------------------
package ctls_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_IDENT,
    MODE_EQ,
    MODE_BANG,
    MODE_LT,
    MODE_GT,
    MODE_DROP
  } mode_e;

  localparam logic [4:0] KIND_NUM    = 5'd0;
  localparam logic [4:0] KIND_IDENT  = 5'd1;
  localparam logic [4:0] KIND_IF     = 5'd2;
  localparam logic [4:0] KIND_ELSE   = 5'd3;
  localparam logic [4:0] KIND_WHILE  = 5'd4;
  localparam logic [4:0] KIND_PLUS   = 5'd5;
  localparam logic [4:0] KIND_MINUS  = 5'd6;
  localparam logic [4:0] KIND_STAR   = 5'd7;
  localparam logic [4:0] KIND_SLASH  = 5'd8;
  localparam logic [4:0] KIND_LPAREN = 5'd9;
  localparam logic [4:0] KIND_RPAREN = 5'd10;
  localparam logic [4:0] KIND_LBRACE = 5'd11;
  localparam logic [4:0] KIND_RBRACE = 5'd12;
  localparam logic [4:0] KIND_SEMI   = 5'd13;
  localparam logic [4:0] KIND_ASSIGN = 5'd14;
  localparam logic [4:0] KIND_EQ     = 5'd15;
  localparam logic [4:0] KIND_NEQ    = 5'd16;
  localparam logic [4:0] KIND_LT     = 5'd17;
  localparam logic [4:0] KIND_LE     = 5'd18;
  localparam logic [4:0] KIND_GT     = 5'd19;
  localparam logic [4:0] KIND_GE     = 5'd20;
  localparam logic [4:0] KIND_END    = 5'd21;
  localparam logic [4:0] KIND_ERR    = 5'd22;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_UNEXP = 2'd1;
  localparam logic [1:0] ERR_BANG  = 2'd2;

  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [7:0]  length;
    logic [1:0]  err;
    logic [7:0]  bad;
  } res_t;

  // All results caused by one input byte; cnt is 1..MAX_RES when queued.
  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [1:0]         cnt;
  } grp_t;

endpackage

// File: hw/rtl/ctls_front.sv
// ----------------------------------------------------------------------------
// ctls_front
// Scanner front end: accepts one byte per transaction, advances the scan
// state and pushes the group of tokens the byte completes into the queue.
// ----------------------------------------------------------------------------
module ctls_front #(
  parameter logic [15:0] POS_LIMIT = 16'hFFFF,
  parameter logic [7:0]  LEN_LIMIT = 8'hFF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    data_byte_i,
  input  logic          last_byte_i,
  input  logic          space_i,
  output logic          push_o,
  output ctls_pkg::grp_t grp_o
);
  import ctls_pkg::*;

  typedef struct packed {
    logic  hit;
    res_t  r;
    mode_e mode;
  } flush_t;

  function automatic res_t mk_res(logic [4:0] kind, logic [15:0] start,
                                  logic [7:0] length, logic [1:0] err,
                                  logic [7:0] bad);
    res_t r;
    r.kind   = kind;
    r.start  = start;
    r.length = length;
    r.err    = err;
    r.bad    = bad;
    return r;
  endfunction

  function automatic grp_t add_res(grp_t g, res_t r);
    grp_t o;
    o = g;
    if (g.cnt != 2'd3) begin
      o.res[g.cnt] = r;
      o.cnt        = g.cnt + 2'd1;
    end
    return o;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [4:0] single_kind(logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      ";":     k = KIND_SEMI;
      default: k = KIND_NUM;
    endcase
    return k;
  endfunction

  // bit 0: if, bit 1: else, bit 2: while
  function automatic logic [2:0] kw_match(logic [7:0] pl, logic [7:0] c);
    logic [2:0] m;
    m[0] = (pl == 8'd0 && c == "i") || (pl == 8'd1 && c == "f");
    m[1] = (pl == 8'd0 && c == "e") || (pl == 8'd1 && c == "l") ||
           (pl == 8'd2 && c == "s") || (pl == 8'd3 && c == "e");
    m[2] = (pl == 8'd0 && c == "w") || (pl == 8'd1 && c == "h") ||
           (pl == 8'd2 && c == "i") || (pl == 8'd3 && c == "l") ||
           (pl == 8'd4 && c == "e");
    return m;
  endfunction

  function automatic logic [4:0] ident_kind(logic [7:0] pl, logic [2:0] kw);
    logic [4:0] k;
    k = KIND_IDENT;
    if (kw[0] && pl == 8'd2) k = KIND_IF;
    if (kw[1] && pl == 8'd4) k = KIND_ELSE;
    if (kw[2] && pl == 8'd5) k = KIND_WHILE;
    return k;
  endfunction

  function automatic flush_t flush_f(mode_e m, logic [15:0] ps, logic [7:0] pl,
                                     logic [2:0] kw);
    flush_t f;
    f.hit  = 1'b1;
    f.mode = MODE_IDLE;
    f.r    = mk_res(KIND_NUM, ps, pl, ERR_NONE, 8'd0);
    unique case (m)
      MODE_NUM:   f.r.kind = KIND_NUM;
      MODE_IDENT: f.r.kind = ident_kind(pl, kw);
      MODE_EQ:    f.r = mk_res(KIND_ASSIGN, ps, 8'd1, ERR_NONE, 8'd0);
      MODE_LT:    f.r = mk_res(KIND_LT, ps, 8'd1, ERR_NONE, 8'd0);
      MODE_GT:    f.r = mk_res(KIND_GT, ps, 8'd1, ERR_NONE, 8'd0);
      MODE_BANG: begin
        f.r    = mk_res(KIND_ERR, ps, 8'd1, ERR_BANG, "!");
        f.mode = MODE_DROP;
      end
      MODE_IDLE:  f.hit = 1'b0;
      MODE_DROP: begin
        f.hit  = 1'b0;
        f.mode = MODE_DROP;
      end
    endcase
    return f;
  endfunction

  mode_e       mode_q, mode_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] pstart_q, pstart_d;
  logic [7:0]  plen_q, plen_d;
  logic [2:0]  kw_q, kw_d;

  grp_t        grp;
  flush_t      fl;
  logic        used;
  logic        two_hit;
  logic [4:0]  two_kind;
  logic [4:0]  kind1;
  logic [15:0] end_pos;
  logic        accept;

  assign in_ready_o = space_i;
  assign accept     = in_valid_i && space_i;

  always_comb begin
    mode_d   = mode_q;
    pstart_d = pstart_q;
    plen_d   = plen_q;
    kw_d     = kw_q;
    pos_d    = pos_q;
    grp      = '0;
    fl       = '0;
    used     = 1'b0;
    two_hit  = 1'b0;
    two_kind = KIND_EQ;
    kind1    = single_kind(data_byte_i);
    end_pos  = (pos_q < POS_LIMIT) ? pos_q + 16'd1 : POS_LIMIT;

    unique case (mode_q)
      MODE_DROP: used = 1'b1;
      MODE_NUM: begin
        if (is_digit(data_byte_i)) begin
          if (plen_q < LEN_LIMIT) plen_d = plen_q + 8'd1;
          used = 1'b1;
        end else begin
          fl = flush_f(mode_q, pstart_q, plen_q, kw_q);
          if (fl.hit) grp = add_res(grp, fl.r);
          mode_d = fl.mode;
        end
      end
      MODE_IDENT: begin
        if (is_alpha(data_byte_i) || is_digit(data_byte_i) || data_byte_i == "_") begin
          kw_d = kw_q & kw_match(plen_q, data_byte_i);
          if (plen_q < LEN_LIMIT) plen_d = plen_q + 8'd1;
          used = 1'b1;
        end else begin
          fl = flush_f(mode_q, pstart_q, plen_q, kw_q);
          if (fl.hit) grp = add_res(grp, fl.r);
          mode_d = fl.mode;
        end
      end
      MODE_EQ: begin
        two_hit  = 1'b1;
        two_kind = KIND_EQ;
      end
      MODE_LT: begin
        two_hit  = 1'b1;
        two_kind = KIND_LE;
      end
      MODE_GT: begin
        two_hit  = 1'b1;
        two_kind = KIND_GE;
      end
      MODE_BANG: begin
        two_hit  = 1'b1;
        two_kind = KIND_NEQ;
      end
      MODE_IDLE: ;
    endcase

    if (two_hit) begin
      if (data_byte_i == "=") begin
        grp    = add_res(grp, mk_res(two_kind, pstart_q, 8'd2, ERR_NONE, 8'd0));
        mode_d = MODE_IDLE;
        used   = 1'b1;
      end else begin
        fl = flush_f(mode_q, pstart_q, plen_q, kw_q);
        if (fl.hit) grp = add_res(grp, fl.r);
        mode_d = fl.mode;
        // the byte after a lone '!' is swallowed
        if (mode_q == MODE_BANG) used = 1'b1;
      end
    end

    if (!used) begin
      priority if (data_byte_i == 8'd0) begin
        grp    = add_res(grp, mk_res(KIND_END, pos_q, 8'd0, ERR_NONE, 8'd0));
        mode_d = MODE_DROP;
      end else if (is_space(data_byte_i)) begin
      end else if (is_digit(data_byte_i)) begin
        mode_d   = MODE_NUM;
        pstart_d = pos_q;
        plen_d   = 8'd1;
      end else if (is_alpha(data_byte_i)) begin
        mode_d   = MODE_IDENT;
        pstart_d = pos_q;
        plen_d   = 8'd1;
        kw_d     = {data_byte_i == "w", data_byte_i == "e", data_byte_i == "i"};
      end else if (kind1 != KIND_NUM) begin
        grp = add_res(grp, mk_res(kind1, pos_q, 8'd1, ERR_NONE, 8'd0));
      end else if (data_byte_i == "=") begin
        mode_d   = MODE_EQ;
        pstart_d = pos_q;
        plen_d   = 8'd1;
      end else if (data_byte_i == "<") begin
        mode_d   = MODE_LT;
        pstart_d = pos_q;
        plen_d   = 8'd1;
      end else if (data_byte_i == ">") begin
        mode_d   = MODE_GT;
        pstart_d = pos_q;
        plen_d   = 8'd1;
      end else if (data_byte_i == "!") begin
        mode_d   = MODE_BANG;
        pstart_d = pos_q;
        plen_d   = 8'd1;
      end else begin
        grp    = add_res(grp, mk_res(KIND_ERR, pos_q, 8'd1, ERR_UNEXP, data_byte_i));
        mode_d = MODE_DROP;
      end
    end

    if (last_byte_i) begin
      if (mode_d != MODE_DROP) begin
        fl = flush_f(mode_d, pstart_d, plen_d, kw_d);
        if (fl.hit) grp = add_res(grp, fl.r);
        if (fl.mode != MODE_DROP) begin
          grp = add_res(grp, mk_res(KIND_END, end_pos, 8'd0, ERR_NONE, 8'd0));
        end
      end
      mode_d   = MODE_IDLE;
      pos_d    = 16'd0;
      pstart_d = 16'd0;
      plen_d   = 8'd0;
      kw_d     = 3'd0;
    end else if (pos_q < POS_LIMIT) begin
      pos_d = pos_q + 16'd1;
    end
  end

  assign push_o = accept && (grp.cnt != 2'd0);
  assign grp_o  = grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pos_q    <= 16'd0;
      pstart_q <= 16'd0;
      plen_q   <= 8'd0;
      kw_q     <= 3'd0;
    end else if (accept) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      pstart_q <= pstart_d;
      plen_q   <= plen_d;
      kw_q     <= kw_d;
    end
  end

endmodule

// File: hw/rtl/ctls_fifo.sv
// ----------------------------------------------------------------------------
// ctls_fifo
// Two-entry queue of result groups between the scanner front end and the
// output stage.
// ----------------------------------------------------------------------------
module ctls_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ctls_pkg::grp_t push_data_i,
  output logic           space_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ctls_pkg::grp_t pop_data_o
);
  import ctls_pkg::*;

  grp_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign space_o    = (count_q != 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// File: hw/rtl/ctls_back.sv
// ----------------------------------------------------------------------------
// ctls_back
// Output stage: takes one result group from the queue and hands its results
// out one transaction at a time, flagging the last of the group.
// ----------------------------------------------------------------------------
module ctls_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  ctls_pkg::grp_t q_data_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ctls_pkg::res_t res_o,
  output logic           run_end_o
);
  import ctls_pkg::*;

  grp_t       grp_q;
  logic       valid_q;
  logic [1:0] idx_q;
  logic       last_res;
  logic       take;

  assign last_res    = (idx_q == grp_q.cnt - 2'd1);
  assign take        = !valid_q || (out_ready_i && last_res);
  assign q_pop_o     = take && q_valid_i;
  assign out_valid_o = valid_q;
  assign res_o       = grp_q.res[idx_q];
  assign run_end_o   = last_res;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) grp_q <= q_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (take) begin
      valid_q <= q_valid_i;
      idx_q   <= 2'd0;
    end else if (out_ready_i) begin
      idx_q <= idx_q + 2'd1;
    end
  end

endmodule

// File: hw/rtl/c_like_token_scanner.sv
// Streaming scanner for a small C-like language. One source byte is taken per
// clock cycle while the two-entry result queue has room; the byte's tokens are
// worked out in the same cycle and queued as one group. The output stage hands
// out one token per cycle while out_ready_i is high, so a byte that completes
// two or three tokens holds the output until all are taken, and input backs up
// once the queue is full. A byte's tokens pass from the result queue into the
// output stage's group register before they are presented at the output.
// Input and output stall independently.
// ----------------------------------------------------------------------------
// c_like_token_scanner
// Top level: byte scanner front end, result queue and output stage.
// ----------------------------------------------------------------------------
module c_like_token_scanner #(
  parameter int unsigned MAX_INPUT_BYTES  = 65536,
  parameter int unsigned MAX_TOKEN_LENGTH = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  token_kind_o,
  output logic [15:0] token_start_o,
  output logic [7:0]  token_length_o,
  output logic [1:0]  error_code_o,
  output logic [7:0]  bad_char_o,
  output logic        run_end_o
);
  import ctls_pkg::*;

  localparam int unsigned POS_LIMIT_INT =
    (MAX_INPUT_BYTES - 1 < 65535) ? MAX_INPUT_BYTES - 1 : 65535;
  localparam int unsigned LEN_LIMIT_INT =
    (MAX_TOKEN_LENGTH < 255) ? MAX_TOKEN_LENGTH : 255;

  logic space;
  logic push;
  grp_t push_grp;
  logic q_valid;
  grp_t q_grp;
  logic q_pop;
  res_t res;

  ctls_front #(
    .POS_LIMIT(16'(POS_LIMIT_INT)),
    .LEN_LIMIT(8'(LEN_LIMIT_INT))
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .space_i    (space),
    .push_o     (push),
    .grp_o      (push_grp)
  );

  ctls_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_grp),
    .space_o    (space),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (q_grp)
  );

  ctls_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_grp),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res),
    .run_end_o  (run_end_o)
  );

  assign token_kind_o   = res.kind;
  assign token_start_o  = res.start;
  assign token_length_o = res.length;
  assign error_code_o   = res.err;
  assign bad_char_o     = res.bad;

  a_end_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == KIND_END |->
      token_length_o == 8'd0 && error_code_o == ERR_NONE && run_end_o)
    else $error("END token malformed");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == KIND_ERR |->
      error_code_o != ERR_NONE && token_length_o == 8'd1 && run_end_o)
    else $error("error token malformed");

  a_ok_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o != KIND_ERR |->
      error_code_o == ERR_NONE && bad_char_o == 8'd0)
    else $error("error fields set on a regular token");

  a_group_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !run_end_o |=> out_valid_o)
    else $error("result group cut short");

endmodule

// File: sim/c_like_token_scanner_tb.sv
// ----------------------------------------------------------------------------
// c_like_token_scanner_tb
// Streams short C-like source texts into the scanner byte by byte. A scoreboard
// scans the same bytes itself, queues the tokens each byte should produce and
// compares every token taken from the output against them. Directed texts cover
// each token kind except KIND_EQ, errors and end markers. Random texts follow,
// with input and output stalls in varying mixes.
// ----------------------------------------------------------------------------
module c_like_token_scanner_tb;
  import ctls_pkg::*;

  localparam logic [15:0] POS_MAX     = 16'hFFFF;
  localparam logic [7:0]  LEN_MAX     = 8'd255;
  localparam int          STALL_LIMIT = 2000;
  localparam int          DRAIN_WAIT  = 20;

  typedef struct packed {
    res_t r;
    logic run_end;
  } tok_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [4:0]  token_kind_o;
  logic [15:0] token_start_o;
  logic [7:0]  token_length_o;
  logic [1:0]  error_code_o;
  logic [7:0]  bad_char_o;
  logic        run_end_o;

  c_like_token_scanner u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_kind_o   (token_kind_o),
    .token_start_o  (token_start_o),
    .token_length_o (token_length_o),
    .error_code_o   (error_code_o),
    .bad_char_o     (bad_char_o),
    .run_end_o      (run_end_o)
  );

  // scanner state mirror
  mode_e       scan_mode;
  logic [15:0] byte_pos;
  logic [15:0] tok_start;
  logic [7:0]  tok_len;
  logic [2:0]  kw_live;   // bit 0 if, bit 1 else, bit 2 while

  tok_t        byte_tokens[$];
  tok_t        expected_tokens[$];
  logic [7:0]  text_buf[$];

  int snd_idle_pct;
  int rcv_idle_pct;
  int n_fail;
  int n_bytes;
  int n_tokens;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    n_fail++;
  endtask

  function automatic int kw_len(int k);
    case (k)
      0: return 2;
      1: return 4;
      default: return 5;
    endcase
  endfunction

  function automatic logic [7:0] kw_char(int k, int idx);
    logic [39:0] w;
    int n;
    case (k)
      0: w = "if";
      1: w = "else";
      default: w = "while";
    endcase
    n = kw_len(k);
    if (idx >= n) return 8'h00;
    return w[8*(n-1-idx) +: 8];
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [4:0] op_kind(logic [7:0] c);
    case (c)
      "+": return KIND_PLUS;
      "-": return KIND_MINUS;
      "*": return KIND_STAR;
      "/": return KIND_SLASH;
      "(": return KIND_LPAREN;
      ")": return KIND_RPAREN;
      "{": return KIND_LBRACE;
      "}": return KIND_RBRACE;
      ";": return KIND_SEMI;
      default: return KIND_NUM;
    endcase
  endfunction

  function automatic void reset_scan();
    scan_mode = MODE_IDLE;
    byte_pos  = '0;
    tok_start = '0;
    tok_len   = '0;
    kw_live   = '0;
  endfunction

  function automatic void add_tok(logic [4:0] k, logic [15:0] s, logic [7:0] l,
                                  logic [1:0] e, logic [7:0] b);
    tok_t t;
    if (byte_tokens.size() >= MAX_RES) return;
    t.r.kind   = k;
    t.r.start  = s;
    t.r.length = l;
    t.r.err    = e;
    t.r.bad    = b;
    t.run_end  = 1'b0;
    byte_tokens.insert(byte_tokens.size(), t);
  endfunction

  function automatic void close_ident();
    logic [4:0] k;
    k = KIND_IDENT;
    for (int i = 0; i < 3; i++)
      if (kw_live[i] && tok_len == kw_len(i)) k = KIND_IF + 5'(i);
    add_tok(k, tok_start, tok_len, ERR_NONE, 8'h00);
  endfunction

  // completes the pending token as if the text ended here
  function automatic void flush_tok();
    case (scan_mode)
      MODE_NUM:   add_tok(KIND_NUM, tok_start, tok_len, ERR_NONE, 8'h00);
      MODE_IDENT: close_ident();
      MODE_EQ:    add_tok(KIND_ASSIGN, tok_start, 8'd1, ERR_NONE, 8'h00);
      MODE_LT:    add_tok(KIND_LT, tok_start, 8'd1, ERR_NONE, 8'h00);
      MODE_GT:    add_tok(KIND_GT, tok_start, 8'd1, ERR_NONE, 8'h00);
      MODE_BANG: begin
        add_tok(KIND_ERR, tok_start, 8'd1, ERR_BANG, "!");
        scan_mode = MODE_DROP;
      end
      default: ;
    endcase
    if (scan_mode != MODE_DROP) scan_mode = MODE_IDLE;
  endfunction

  function automatic void open_tok(mode_e m, logic [15:0] p);
    scan_mode = m;
    tok_start = p;
    tok_len   = 8'd1;
  endfunction

  function automatic void predict_tokens(logic [7:0] c, logic last);
    logic [15:0] p;
    bit          used;
    bit          has_two;
    bit          was_bang;
    logic [4:0]  two;
    tok_t        t;
    p        = byte_pos;
    used     = 1'b0;
    has_two  = 1'b0;
    two      = KIND_EQ;
    byte_tokens.delete();
    case (scan_mode)
      MODE_DROP: used = 1'b1;
      MODE_NUM: begin
        if (is_digit(c)) begin
          if (tok_len < LEN_MAX) tok_len++;
          used = 1'b1;
        end else begin
          flush_tok();
        end
      end
      MODE_IDENT: begin
        if (is_alpha(c) || is_digit(c) || c == "_") begin
          for (int i = 0; i < 3; i++)
            if (!(tok_len < kw_len(i) && kw_char(i, tok_len) == c)) kw_live[i] = 1'b0;
          if (tok_len < LEN_MAX) tok_len++;
          used = 1'b1;
        end else begin
          flush_tok();
        end
      end
      MODE_EQ: begin
        has_two = 1'b1;
        two     = KIND_EQ;
      end
      MODE_LT: begin
        has_two = 1'b1;
        two     = KIND_LE;
      end
      MODE_GT: begin
        has_two = 1'b1;
        two     = KIND_GE;
      end
      MODE_BANG: begin
        has_two = 1'b1;
        two     = KIND_NEQ;
      end
      default: ;
    endcase

    if (has_two) begin
      if (c == "=") begin
        add_tok(two, tok_start, 8'd2, ERR_NONE, 8'h00);
        scan_mode = MODE_IDLE;
        used      = 1'b1;
      end else begin
        was_bang = (scan_mode == MODE_BANG);
        flush_tok();
        if (was_bang) used = 1'b1;
      end
    end

    if (!used) begin
      if (c == 8'h00) begin
        add_tok(KIND_END, p, 8'd0, ERR_NONE, 8'h00);
        scan_mode = MODE_DROP;
      end else if (is_space(c)) begin
      end else if (is_digit(c)) begin
        open_tok(MODE_NUM, p);
      end else if (is_alpha(c)) begin
        open_tok(MODE_IDENT, p);
        kw_live = {c == "w", c == "e", c == "i"};
      end else if (op_kind(c) != KIND_NUM) begin
        add_tok(op_kind(c), p, 8'd1, ERR_NONE, 8'h00);
      end else if (c == "=") begin
        open_tok(MODE_EQ, p);
      end else if (c == "<") begin
        open_tok(MODE_LT, p);
      end else if (c == ">") begin
        open_tok(MODE_GT, p);
      end else if (c == "!") begin
        open_tok(MODE_BANG, p);
      end else begin
        add_tok(KIND_ERR, p, 8'd1, ERR_UNEXP, c);
        scan_mode = MODE_DROP;
      end
    end

    if (last) begin
      if (scan_mode != MODE_DROP) begin
        flush_tok();
        if (scan_mode != MODE_DROP)
          add_tok(KIND_END, (p < POS_MAX) ? p + 16'd1 : POS_MAX, 8'd0, ERR_NONE, 8'h00);
      end
      reset_scan();
    end else if (byte_pos < POS_MAX) begin
      byte_pos++;
    end

    if (byte_tokens.size() > 0) begin
      t = byte_tokens[byte_tokens.size() - 1];
      t.run_end = 1'b1;
      byte_tokens[byte_tokens.size() - 1] = t;
    end
    foreach (byte_tokens[i]) expected_tokens.insert(expected_tokens.size(), byte_tokens[i]);
  endfunction

  // ---- driving ----

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    predict_tokens(b, last);
    n_bytes++;
    @(negedge clk_i);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_buf();
    for (int i = 0; i < text_buf.size(); i++) send_byte(text_buf[i], i == text_buf.size() - 1);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_tokens.size() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i) out_ready_i <= ($urandom_range(0, 99) >= rcv_idle_pct);

  // ---- checking ----

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("token %0d %s got %0d want %0d", n_tokens, name, got, want));
  endtask

  always @(posedge clk_i) begin : chk_tokens
    tok_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("token %0d unexpected kind %0d start %0d", n_tokens,
                                  token_kind_o, token_start_o));
      end else begin
        want = expected_tokens.pop_front();
        check_field("kind", token_kind_o, want.r.kind);
        check_field("start", token_start_o, want.r.start);
        check_field("length", token_length_o, want.r.length);
        check_field("error_code", error_code_o, want.r.err);
        check_field("bad_char", bad_char_o, want.r.bad);
        check_field("run_end", run_end_o, want.run_end);
      end
      n_tokens++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("c_like_token_scanner_tb NOT OK");
      $finish;
    end
  end

  // ---- random text generation ----

  function automatic void put_char(logic [7:0] c);
    text_buf.insert(text_buf.size(), c);
  endfunction

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25)) : 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_word_char();
    case ($urandom_range(0, 3))
      0: return 8'("0" + $urandom_range(0, 9));
      1: return "_";
      default: return rand_letter();
    endcase
  endfunction

  function automatic logic [7:0] rand_space();
    int r;
    r = $urandom_range(8, 13);
    return (r == 8) ? " " : 8'(r);
  endfunction

  task automatic add_ident();
    case ($urandom_range(0, 11))
      0: add_str("if");
      1: add_str("else");
      2: add_str("while");
      3: add_str("wh");
      4: add_str("els");
      5: add_str("iff");
      6: add_str("while_");
      7: add_str("else9");
      default: begin
        put_char(rand_letter());
        repeat ($urandom_range(0, 5)) put_char(rand_word_char());
      end
    endcase
  endtask

  task automatic add_noise();
    case ($urandom_range(0, 4))
      0: put_char("!");
      1: put_char(8'h00);
      2: put_char(8'($urandom_range(128, 255)));
      default: put_char(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic build_text(bit noisy);
    int    ntok;
    int    noise_at;
    string ops;
    ops = "+-*/(){};";
    text_buf.delete();
    ntok     = $urandom_range(1, 10);
    noise_at = noisy ? $urandom_range(0, ntok - 1) : -1;
    for (int i = 0; i < ntok; i++) begin
      if (i == noise_at) add_noise();
      case ($urandom_range(0, 9))
        0, 1: repeat ($urandom_range(1, 4)) put_char(8'("0" + $urandom_range(0, 9)));
        2, 3: add_ident();
        4, 5: put_char(ops[$urandom_range(0, 8)]);
        6, 7: begin
          case ($urandom_range(0, 6))
            0: add_str("=");
            1: add_str("==");
            2: add_str("!=");
            3: add_str("<");
            4: add_str("<=");
            5: add_str(">");
            default: add_str(">=");
          endcase
        end
        default: repeat ($urandom_range(1, 2)) put_char(rand_space());
      endcase
      if ($urandom_range(0, 1)) put_char(" ");
    end
    if ($urandom_range(0, 4) == 0) put_char(rand_space());
  endtask

  // ---- tests ----

  task automatic test_keywords_and_punct();
    send_text("if(else)while");
    send_text("x_9=7;{-}");
  endtask

  task automatic test_operators();
    send_text("<>!=<==>=+*/ ");
  endtask

  task automatic test_errors();
    send_text("!a#");
    send_byte(8'hFF, 1'b1);
    send_text("+!");
  endtask

  task automatic test_end_markers();
    send_byte("7", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte("q", 1'b1);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_random(int count);
    int stop_at;
    stop_at = n_bytes + count;
    while (n_bytes < stop_at) begin
      build_text($urandom_range(0, 4) == 0);
      send_buf();
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    data_byte_i  = 8'h00;
    last_byte_i  = 1'b0;
    out_ready_i  = 1'b0;
    n_fail       = 0;
    n_bytes      = 0;
    n_tokens     = 0;
    idle_cycles  = 0;
    snd_idle_pct = 26;
    rcv_idle_pct = 66;
    reset_scan();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_keywords_and_punct();
    test_operators();
    test_errors();
    test_end_markers();
    test_random(70);

    snd_idle_pct = 66;
    rcv_idle_pct = 26;
    test_random(35);
    wait_drain();
    test_random(35);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random(70);

    wait_drain();
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (n_fail == 0) begin
      $display("c_like_token_scanner_tb OK");
    end else begin
      $display("c_like_token_scanner_tb NOT OK");
    end
    $finish;
  end

endmodule
